@@ rtl/hds_pkg.sv @@
`default_nettype none

package hds_pkg;

    // Defaults for the top level parameters
    localparam int GRID_DIM_DEF  = 64;
    localparam int MAX_SPLAT_DEF = 8;

    // Field widths
    localparam int CFG_W       = 48;
    localparam int CFG_IDX_W   = 3;
    localparam int COLOR_W     = 48;
    localparam int CELL_W      = 6;
    localparam int RADIUS_W    = 4;
    localparam int COORD_W_MAX = 11;

    // Arithmetic widths of the projection datapath
    localparam int DOT_W = 34;
    localparam int R_W   = 19;
    localparam int R2_W  = 2 * R_W + 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd4;

    // Kind of work handed from the front to the back
    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_SPLAT = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [COORD_W_MAX-1:0]   px;
        logic [COORD_W_MAX-1:0]   py;
        logic [COLOR_W-1:0]       color;
        logic [CELL_W-1:0]        cell_x;
        logic [CELL_W-1:0]        cell_y;
    } q_entry_t;

endpackage

`default_nettype wire

@@ rtl/hds_ram.sv @@
`default_nettype none

module hds_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/hds_queue.sv @@
`default_nettype none

module hds_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire hds_pkg::q_entry_t push_entry,
    output logic                   full,
    input  wire logic              pop,
    output hds_pkg::q_entry_t      head,
    output logic                   empty
);

    import hds_pkg::*;

    q_entry_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && push |-> pop) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop) else $error("queue pop while empty");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not advance");
`endif

endmodule

`default_nettype wire

@@ rtl/hds_front.sv @@
`default_nettype none

module hds_front #(
    parameter int GRID_DIM = hds_pkg::GRID_DIM_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          take,
    output logic                               front_busy,
    input  wire logic                          action,
    input  wire logic signed [15:0]            dir_x,
    input  wire logic signed [15:0]            dir_y,
    input  wire logic signed [15:0]            dir_z,
    input  wire logic [hds_pkg::COLOR_W-1:0]   color,
    input  wire logic [hds_pkg::CELL_W-1:0]    cell_x,
    input  wire logic [hds_pkg::CELL_W-1:0]    cell_y,
    input  wire logic [hds_pkg::CFG_W-1:0]     frame_row_x,
    input  wire logic [hds_pkg::CFG_W-1:0]     frame_row_y,
    input  wire logic [hds_pkg::CFG_W-1:0]     frame_row_z,
    input  wire logic [hds_pkg::CFG_W-1:0]     patch_normal,
    input  wire logic                          q_full,
    output logic                               push,
    output hds_pkg::q_entry_t                  push_entry
);

    import hds_pkg::*;

    localparam int CW      = $clog2(GRID_DIM + 1);
    localparam int BW      = $clog2(CW);
    localparam int A_W     = CW + 2;
    localparam int ASQ_W   = 2 * CW;
    localparam int BABS_W  = R_W + CW;
    localparam int BSQ_W   = 2 * BABS_W;
    localparam int LHS_W   = ASQ_W + R2_W;

    typedef enum logic [8:0] {
        F_IDLE = 9'b000000001,
        F_MAC  = 9'b000000010,
        F_SQ   = 9'b000000100,
        F_SUM  = 9'b000001000,
        F_BSQ  = 9'b000010000,
        F_A    = 9'b000100000,
        F_P    = 9'b001000000,
        F_CMP  = 9'b010000000,
        F_PUSH = 9'b100000000
    } fstate_t;

    fstate_t state_reg, state_next;
    logic [1:0]    j_reg, j_next;
    logic [BW-1:0] bit_reg, bit_next;

    // Item payload and datapath registers
    cmd_kind_t               kind_reg;
    logic signed [15:0]      d_reg [3];
    logic [COLOR_W-1:0]      color_reg;
    logic [CELL_W-1:0]       cx_reg, cy_reg;
    logic signed [DOT_W-1:0] dot_reg [4];
    logic signed [R_W-1:0]   r_reg [2];
    logic [2*R_W-1:0]        sq_reg [3];
    logic [R2_W-1:0]         r2_reg;
    logic [BABS_W-1:0]       babs_reg [2];
    logic                    bneg_reg [2];
    logic [BSQ_W-1:0]        bsq_reg [2];
    logic [CW-1:0]           c_reg [2];
    logic [CW-1:0]           t_reg [2];
    logic [ASQ_W-1:0]        asq_reg [2];
    logic                    ale0_reg [2];
    logic                    age0_reg [2];
    logic [LHS_W-1:0]        lhs_reg [2];

    logic [CFG_W-1:0]        row_sel;
    logic signed [31:0]      prod [3];
    logic signed [DOT_W-1:0] mac;
    logic signed [R_W-1:0]   r_now [3];
    logic signed [2*R_W-1:0] sq_now [3];
    logic [R_W-1:0]          r_abs [2];
    logic [CW-1:0]           t_now [2];
    logic signed [A_W-1:0]   a_now [2];
    logic [CW-1:0]           a_abs [2];
    logic                    pass [2];
    logic                    off_grid;

    assign front_busy = (state_reg != F_IDLE);

    // Select the row for this multiply-accumulate step
    always_comb
    begin
        case (j_reg)
            2'd0:    row_sel = patch_normal;
            2'd1:    row_sel = frame_row_x;
            2'd2:    row_sel = frame_row_y;
            default: row_sel = frame_row_z;
        endcase
        prod[0] = $signed(row_sel[15:0])  * d_reg[0];
        prod[1] = $signed(row_sel[31:16]) * d_reg[1];
        prod[2] = $signed(row_sel[47:32]) * d_reg[2];
        mac = DOT_W'(prod[0]) + DOT_W'(prod[1]) + DOT_W'(prod[2]);
    end

    // Floor to Q14 units and square
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r_now[i]  = dot_reg[i + 1][14 + R_W - 1:14];
            sq_now[i] = r_now[i] * r_now[i];
        end
    end

    // Lane arithmetic of the coordinate search
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            r_abs[l] = r_reg[l][R_W-1] ? R_W'(-r_reg[l]) : R_W'(r_reg[l]);
            t_now[l] = c_reg[l] | (CW'(1) << bit_reg);
            a_now[l] = (A_W'(t_now[l]) << 1) - A_W'(GRID_DIM);
            a_abs[l] = a_now[l][A_W-1] ? CW'(-a_now[l]) : CW'(a_now[l]);
            if (!bneg_reg[l])
            begin
                pass[l] = ale0_reg[l] || (LHS_W'(lhs_reg[l]) <= LHS_W'(bsq_reg[l]));
            end
            else
            begin
                pass[l] = !age0_reg[l] && (LHS_W'(lhs_reg[l]) >= LHS_W'(bsq_reg[l]));
            end
        end
        off_grid = (32'(c_reg[0]) >= 32'(GRID_DIM)) || (32'(c_reg[1]) >= 32'(GRID_DIM));
    end

    // Sequence the steps of one item
    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        bit_next   = bit_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (take)
                begin
                    j_next     = 2'd0;
                    state_next = action ? F_PUSH : F_MAC;
                end
            end
            F_MAC:
            begin
                j_next = j_reg + 2'd1;
                if (j_reg == 2'd3)
                begin
                    state_next = F_SQ;
                end
            end
            F_SQ:
            begin
                state_next = dot_reg[0][DOT_W-1] ? F_PUSH : F_SUM;
            end
            F_SUM:
            begin
                state_next = F_BSQ;
            end
            F_BSQ:
            begin
                bit_next   = BW'(CW - 1);
                state_next = (r2_reg == '0) ? F_PUSH : F_A;
            end
            F_A:
            begin
                state_next = F_P;
            end
            F_P:
            begin
                state_next = F_CMP;
            end
            F_CMP:
            begin
                if (bit_reg == '0)
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    bit_next   = bit_reg - BW'(1);
                    state_next = F_A;
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            j_reg     <= 2'd0;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            bit_reg   <= bit_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (take)
                begin
                    kind_reg  <= action ? CMD_READ : CMD_SPLAT;
                    d_reg[0]  <= dir_x;
                    d_reg[1]  <= dir_y;
                    d_reg[2]  <= dir_z;
                    color_reg <= color;
                    cx_reg    <= cell_x;
                    cy_reg    <= cell_y;
                end
            end
            F_MAC:
            begin
                dot_reg[j_reg] <= mac;
            end
            F_SQ:
            begin
                if (dot_reg[0][DOT_W-1])
                begin
                    kind_reg <= CMD_NONE;
                end
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[i] <= sq_now[i];
                end
                r_reg[0] <= r_now[0];
                r_reg[1] <= r_now[1];
            end
            F_SUM:
            begin
                r2_reg <= R2_W'(sq_reg[0]) + R2_W'(sq_reg[1]) + R2_W'(sq_reg[2]);
                for (int l = 0; l < 2; l++)
                begin
                    babs_reg[l] <= BABS_W'(r_abs[l]) * BABS_W'(GRID_DIM);
                    bneg_reg[l] <= r_reg[l][R_W-1];
                end
            end
            F_BSQ:
            begin
                if (r2_reg == '0)
                begin
                    kind_reg <= CMD_NONE;
                end
                for (int l = 0; l < 2; l++)
                begin
                    bsq_reg[l] <= BSQ_W'(babs_reg[l]) * BSQ_W'(babs_reg[l]);
                    c_reg[l]   <= '0;
                end
            end
            F_A:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    t_reg[l]    <= t_now[l];
                    asq_reg[l]  <= ASQ_W'(a_abs[l]) * ASQ_W'(a_abs[l]);
                    ale0_reg[l] <= a_now[l][A_W-1] || (a_now[l] == '0);
                    age0_reg[l] <= !a_now[l][A_W-1];
                end
            end
            F_P:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    lhs_reg[l] <= LHS_W'(asq_reg[l]) * LHS_W'(r2_reg);
                end
            end
            F_CMP:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    if ((32'(t_reg[l]) <= 32'(GRID_DIM)) && pass[l])
                    begin
                        c_reg[l] <= t_reg[l];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Build the request for the back
    always_comb
    begin
        push              = (state_reg == F_PUSH) && !q_full;
        push_entry.kind   = ((kind_reg == CMD_SPLAT) && off_grid) ? CMD_NONE : kind_reg;
        push_entry.px     = COORD_W_MAX'(c_reg[0]);
        push_entry.py     = COORD_W_MAX'(c_reg[1]);
        push_entry.color  = color_reg;
        push_entry.cell_x = cx_reg;
        push_entry.cell_y = cy_reg;
    end

`ifndef SYNTHESIS
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> state_reg == F_IDLE) else $error("item taken while front busy");
    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == F_PUSH && kind_reg == CMD_SPLAT
        |-> 32'(c_reg[0]) <= 32'(GRID_DIM) && 32'(c_reg[1]) <= 32'(GRID_DIM))
        else $error("coordinate above grid size");
    a_push_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> state_reg == F_IDLE) else $error("front did not return to idle");
`endif

endmodule

`default_nettype wire

@@ rtl/hds_back.sv @@
`default_nettype none

module hds_back #(
    parameter int GRID_DIM  = hds_pkg::GRID_DIM_DEF,
    parameter int MAX_SPLAT = hds_pkg::MAX_SPLAT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire hds_pkg::q_entry_t              head,
    input  wire logic                           q_empty,
    output logic                                pop,
    input  wire logic [hds_pkg::RADIUS_W-1:0]   splat_radius,
    output logic                                clearing,
    output logic                                done,
    output logic                                accepted,
    output logic [5:0]                          proj_x,
    output logic [5:0]                          proj_y,
    output logic [15:0]                         cell_r,
    output logic [15:0]                         cell_g,
    output logic [15:0]                         cell_b
);

    import hds_pkg::*;

    localparam int DEPTH = GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(GRID_DIM + 1);
    localparam int RDW   = $clog2(MAX_SPLAT + 1);
    localparam int KW    = RDW + 1;
    localparam int XW    = CW + KW + 1;

    typedef enum logic [3:0] {
        B_CLEAR = 4'b0001,
        B_IDLE  = 4'b0010,
        B_RD    = 4'b0100,
        B_SPLAT = 4'b1000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic [AW-1:0]         clr_reg, clr_next;
    logic signed [KW-1:0]  k1_reg, k1_next, k2_reg, k2_next;
    logic signed [KW-1:0]  klast_reg, klast_next;
    logic                  done_reg, done_next;
    logic                  acc_reg, acc_next;
    logic [CW-1:0]         px_reg, px_next, py_reg, py_next;
    logic [COLOR_W-1:0]    color_reg, color_next;
    logic [5:0]            projx_reg, projx_next, projy_reg, projy_next;
    logic [COLOR_W-1:0]    cell_reg, cell_next;

    logic                  wr_en, rd_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [COLOR_W-1:0]    wr_data, rd_data;
    logic [RDW-1:0]        rad;
    logic signed [XW-1:0]  sx, sy;
    logic                  in_grid_rd;

    hds_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign clearing = (state_reg == B_CLEAR);
    assign done     = done_reg;
    assign accepted = acc_reg;
    assign proj_x   = projx_reg;
    assign proj_y   = projy_reg;
    assign cell_r   = cell_reg[15:0];
    assign cell_g   = cell_reg[31:16];
    assign cell_b   = cell_reg[47:32];

    // Saturate the radius and place the current splat cell
    always_comb
    begin
        rad = (32'(splat_radius) > MAX_SPLAT) ? RDW'(MAX_SPLAT) : RDW'(splat_radius);
        sx  = XW'($signed({1'b0, px_reg})) + XW'(k1_reg);
        sy  = XW'($signed({1'b0, py_reg})) + XW'(k2_reg);
        in_grid_rd = (32'(head.cell_x) < 32'(GRID_DIM))
                  && (32'(head.cell_y) < 32'(GRID_DIM));
        rd_addr = AW'(head.cell_x) * AW'(GRID_DIM) + AW'(head.cell_y);
    end

    // Carry out requests one at a time
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        k1_next    = k1_reg;
        k2_next    = k2_reg;
        klast_next = klast_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        color_next = color_reg;
        projx_next = projx_reg;
        projy_next = projy_reg;
        cell_next  = cell_reg;
        pop        = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wr_data    = '0;
        rd_en      = 1'b0;
        case (state_reg)
            B_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (32'(clr_reg) == DEPTH - 1)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    acc_next   = 1'b0;
                    projx_next = '0;
                    projy_next = '0;
                    cell_next  = '0;
                    case (head.kind)
                        CMD_READ:
                        begin
                            if (in_grid_rd)
                            begin
                                rd_en      = 1'b1;
                                state_next = B_RD;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        CMD_SPLAT:
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = AW'(head.px) * AW'(GRID_DIM) + AW'(head.py);
                            wr_data    = head.color;
                            px_next    = CW'(head.px);
                            py_next    = CW'(head.py);
                            color_next = head.color;
                            projx_next = head.px[5:0];
                            projy_next = head.py[5:0];
                            k1_next    = -KW'(rad);
                            k2_next    = -KW'(rad);
                            klast_next = KW'(rad) - KW'(1);
                            if (rad == '0)
                            begin
                                acc_next  = 1'b1;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = B_SPLAT;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            B_RD:
            begin
                cell_next  = rd_data;
                done_next  = 1'b1;
                state_next = B_IDLE;
            end
            B_SPLAT:
            begin
                // Write the clipped square, one cell a cycle
                if (!sx[XW-1] && (sx < XW'(GRID_DIM)) && !sy[XW-1] && (sy < XW'(GRID_DIM)))
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(sx) * AW'(GRID_DIM) + AW'(sy);
                    wr_data = color_reg;
                end
                if (k2_reg == klast_reg)
                begin
                    k2_next = -klast_reg - KW'(1);
                    k1_next = k1_reg + KW'(1);
                    if (k1_reg == klast_reg)
                    begin
                        acc_next   = 1'b1;
                        done_next  = 1'b1;
                        state_next = B_IDLE;
                    end
                end
                else
                begin
                    k2_next = k2_reg + KW'(1);
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg    <= k1_next;
        k2_reg    <= k2_next;
        klast_reg <= klast_next;
        acc_reg   <= acc_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        color_reg <= color_next;
        projx_reg <= projx_next;
        projy_reg <= projy_next;
        cell_reg  <= cell_next;
    end

`ifndef SYNTHESIS
    a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> 32'(wr_addr) < DEPTH) else $error("grid write out of range");
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_CLEAR |=> !done_reg) else $error("result during clear");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == B_IDLE) else $error("pop outside idle");
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_RD |=> done_reg && !acc_reg) else $error("read result missing");
`endif

endmodule

`default_nettype wire

@@ rtl/hemisphere_direction_splat_top.sv @@
`default_nettype none

// Hemisphere direction splat.
// Requests: start with action, direction, color and cell fields; a request is
// taken at a clock edge with start high and busy low. A splat request keeps
// the direction when it faces the patch normal, rotates it by the frame,
// projects it onto the grid and paints a square of cells; a read request
// returns the color of one cell.
// Results: one per request, shown for one cycle with done high; the receiver
// cannot stall, so results are never held back.
// A read passes the front without computation and is pushed to the queue; the back
// reads the cell and shows its color. A splat runs the front's multiply-accumulate,
// square, sum and search steps (log2(GRID)+1 search steps, each through the A, P
// and CMP states), then the back writes the centre cell and the clipped
// (2*radius)^2 square, one write a cycle through the grid's single write port,
// and shows the result. The front is free for the next request once it has pushed
// the last one to the queue; a two-entry queue lets it run ahead while the back paints.
// Configuration: write enable, index and data; write only while idle.
// Reset: the grid's GRID*GRID cells (4096 at the default size) are cleared one cell a
// cycle with busy high; configuration writes are taken meanwhile.

module hemisphere_direction_splat_top #(
    parameter int GRID_DIM  = hds_pkg::GRID_DIM_DEF,
    parameter int MAX_SPLAT = hds_pkg::MAX_SPLAT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [hds_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  wire logic [hds_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            action,
    input  wire logic signed [15:0]              dir_x,
    input  wire logic signed [15:0]              dir_y,
    input  wire logic signed [15:0]              dir_z,
    input  wire logic [15:0]                     color_r,
    input  wire logic [15:0]                     color_g,
    input  wire logic [15:0]                     color_b,
    input  wire logic [5:0]                      cell_x,
    input  wire logic [5:0]                      cell_y,
    output logic                                 done,
    output logic                                 accepted,
    output logic [5:0]                           proj_x,
    output logic [5:0]                           proj_y,
    output logic [15:0]                          cell_r,
    output logic [15:0]                          cell_g,
    output logic [15:0]                          cell_b
);

    import hds_pkg::*;

    logic [CFG_W-1:0]    frame_x_reg, frame_y_reg, frame_z_reg, normal_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic                front_busy, clearing, take;
    logic                q_full, q_empty, push, pop;
    q_entry_t            push_entry, head;

    assign busy = front_busy || clearing;
    assign take = start && !busy;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_x_reg <= 48'h0000_0000_4000;
            frame_y_reg <= 48'h0000_4000_0000;
            frame_z_reg <= 48'h4000_0000_0000;
            normal_reg  <= 48'h4000_0000_0000;
            radius_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FRAME_X: frame_x_reg <= cfg_wdata;
                REG_FRAME_Y: frame_y_reg <= cfg_wdata;
                REG_FRAME_Z: frame_z_reg <= cfg_wdata;
                REG_NORMAL:  normal_reg  <= cfg_wdata;
                REG_RADIUS:  radius_reg  <= cfg_wdata[RADIUS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    hds_front #(
        .GRID_DIM (GRID_DIM)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .front_busy   (front_busy),
        .action       (action),
        .dir_x        (dir_x),
        .dir_y        (dir_y),
        .dir_z        (dir_z),
        .color        ({color_b, color_g, color_r}),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .frame_row_x  (frame_x_reg),
        .frame_row_y  (frame_y_reg),
        .frame_row_z  (frame_z_reg),
        .patch_normal (normal_reg),
        .q_full       (q_full),
        .push         (push),
        .push_entry   (push_entry)
    );

    hds_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    hds_back #(
        .GRID_DIM  (GRID_DIM),
        .MAX_SPLAT (MAX_SPLAT)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .splat_radius (radius_reg),
        .clearing     (clearing),
        .done         (done),
        .accepted     (accepted),
        .proj_x       (proj_x),
        .proj_y       (proj_y),
        .cell_r       (cell_r),
        .cell_g       (cell_g),
        .cell_b       (cell_b)
    );

endmodule

`default_nettype wire
